/* rtl/pgpt_pkg.sv */
package pgpt_pkg;

   localparam int unsigned TABLE_LEN = 24;
   localparam int unsigned ZW = 34;      // residual angle width, Q30
   localparam int unsigned CW = 34;      // cordic x/y width, Q30
   localparam int unsigned EW = 18;      // rotation entry width, Q2.16

   localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
   localparam logic signed [CW-1:0] Q30_GAIN    = 34'sd652032874;

   localparam logic [3:0] REG_COLUMNS  = 4'd0;
   localparam logic [3:0] REG_ROWS     = 4'd1;
   localparam logic [3:0] REG_COL_SPC  = 4'd2;
   localparam logic [3:0] REG_ROW_SPC  = 4'd3;

   typedef struct packed {
      logic signed [15:0] angle_z;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_x;
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic signed [31:0] shift_z;
   } pose_type;

   typedef struct packed {
      logic signed [EW-1:0] r00;
      logic signed [EW-1:0] r01;
      logic signed [EW-1:0] r10;
      logic signed [EW-1:0] r11;
      logic signed [EW-1:0] r20;
      logic signed [EW-1:0] r21;
      logic signed [31:0]   tx;
      logic signed [31:0]   ty;
      logic signed [31:0]   tz;
   } plane_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
      logic signed [ZW-1:0] v;
      begin
         case (i)
            5'd0: v = 34'sh3243F6A8;
            5'd1: v = 34'sh1DAC6705;
            5'd2: v = 34'sh0FADBAFC;
            5'd3: v = 34'sh07F56EA6;
            5'd4: v = 34'sh03FEAB76;
            5'd5: v = 34'sh01FFD55B;
            5'd6: v = 34'sh00FFFAAA;
            5'd7: v = 34'sh007FFF55;
            5'd8: v = 34'sh003FFFEA;
            5'd9: v = 34'sh001FFFFD;
            5'd10: v = 34'sh000FFFFF;
            5'd11: v = 34'sh0007FFFF;
            5'd12: v = 34'sh0003FFFF;
            5'd13: v = 34'sh0001FFFF;
            5'd14: v = 34'sh0000FFFF;
            5'd15: v = 34'sh00007FFF;
            5'd16: v = 34'sh00003FFF;
            5'd17: v = 34'sh00001FFF;
            5'd18: v = 34'sh00000FFF;
            5'd19: v = 34'sh000007FF;
            5'd20: v = 34'sh000003FF;
            5'd21: v = 34'sh000001FF;
            5'd22: v = 34'sh000000FF;
            5'd23: v = 34'sh0000007F;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

/* rtl/pgpt_setup.sv */
// Front: one shared CORDIC for the three angles, then a sequenced
// multiplier that forms the six needed rotation entries.
module pgpt_setup
   import pgpt_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pose_type  in_pose,
   output logic      out_valid,
   input  logic      out_ready,
   output plane_type out_plane
);

   localparam int unsigned STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CORD = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DONE = 3'd3;

   logic [2:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] ang_ff, ang_in;
   logic [3:0] mop_ff, mop_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic neg_ff, neg_in;
   logic signed [CW-1:0] sn_ff [3];
   logic signed [CW-1:0] cs_ff [3];
   logic signed [CW-1:0] p_ff [4];
   pose_type pose_ff;
   plane_type plane_ff;

   logic signed [ZW-1:0] z0, zq;
   logic signed [15:0] ang_sel;
   logic signed [CW-1:0] xs, ys;
   logic signed [CW-1:0] ma, mb;
   logic signed [2*CW-1:0] prod;
   logic signed [CW-1:0] prod_r;

   always_comb begin
      case (ang_ff)
         2'd0: ang_sel = pose_ff.angle_z;
         2'd1: ang_sel = pose_ff.angle_y;
         default: ang_sel = pose_ff.angle_x;
      endcase
      z0 = {{(ZW-33){ang_sel[15]}}, ang_sel, 17'd0};
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
   end

   // product table: cz=cs0 sz=sn0 cy=cs1 sy=sn1 cx=cs2 sx=sn2
   // p0=czsy p1=szsy p2=czsy*sx p3=szsy*sx
   // entries: r00=cz*cy r01=p2-sz*cx r10=sz*cy r11=p3+cz*cx r21=cy*sx, r20=-sy
   always_comb begin
      case (mop_ff)
         4'd0: begin ma = cs_ff[0]; mb = sn_ff[1]; end
         4'd1: begin ma = sn_ff[0]; mb = sn_ff[1]; end
         4'd2: begin ma = cs_ff[0]; mb = cs_ff[1]; end
         4'd3: begin ma = p_ff[0];  mb = sn_ff[2]; end
         4'd4: begin ma = sn_ff[0]; mb = cs_ff[2]; end
         4'd5: begin ma = sn_ff[0]; mb = cs_ff[1]; end
         4'd6: begin ma = p_ff[1];  mb = sn_ff[2]; end
         4'd7: begin ma = cs_ff[0]; mb = cs_ff[2]; end
         default: begin ma = cs_ff[1]; mb = sn_ff[2]; end
      endcase
      prod = ma * mb;
      prod_r = CW'((prod + (2*CW)'(64'sd1 <<< 29)) >>> 30);
   end

   function automatic logic signed [EW-1:0] to_entry(input logic signed [CW:0] v);
      logic signed [CW:0] r;
      begin
         r = (v + (CW+1)'(8192)) >>> 14;
         if (r > (CW+1)'(131071)) return 18'sd131071;
         else if (r < -(CW+1)'(131072)) return -18'sd131072;
         else return r[EW-1:0];
      end
   endfunction

   logic sn_we, cs_we;
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      ang_in = ang_ff;
      mop_in = mop_ff;
      z_in = z_ff;
      x_in = x_ff;
      y_in = y_ff;
      neg_in = neg_ff;
      zq = z0;
      sn_we = 1'b0;
      cs_we = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               state_in = S_CORD;
               ang_in = 2'd0;
               step_in = 5'd31;
            end
         end
         S_CORD: begin
            if (step_ff == 5'd31) begin
               // load the next angle with quadrant folding
               neg_in = 1'b0;
               if (z0 > Q30_HALF_PI) begin
                  zq = z0 - Q30_PI; neg_in = 1'b1;
               end else if (z0 < -Q30_HALF_PI) begin
                  zq = z0 + Q30_PI; neg_in = 1'b1;
               end
               z_in = zq;
               x_in = Q30_GAIN;
               y_in = '0;
               step_in = 5'd0;
            end else begin
               if (!z_ff[ZW-1]) begin
                  x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - atan_q30(step_ff);
               end else begin
                  x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + atan_q30(step_ff);
               end
               if (step_ff == 5'(STEPS - 1)) begin
                  sn_we = 1'b1;
                  cs_we = 1'b1;
                  step_in = 5'd31;
                  if (ang_ff == 2'd2) begin
                     state_in = S_MUL;
                     mop_in = 4'd0;
                  end else begin
                     ang_in = ang_ff + 2'd1;
                  end
               end else begin
                  step_in = step_ff + 5'd1;
               end
            end
         end
         S_MUL: begin
            mop_in = mop_ff + 4'd1;
            if (mop_ff == 4'd9) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= 5'd31;
         ang_ff <= 2'd0;
         mop_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         ang_ff <= ang_in;
         mop_ff <= mop_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;
      x_ff <= x_in;
      y_ff <= y_in;
      neg_ff <= neg_in;
      if (state_ff == S_IDLE && in_valid) pose_ff <= in_pose;
      if (sn_we) sn_ff[ang_ff] <= neg_ff ? -y_in : y_in;
      if (cs_we) cs_ff[ang_ff] <= neg_ff ? -x_in : x_in;
      if (state_ff == S_MUL) begin
         case (mop_ff)
            4'd0: p_ff[0] <= prod_r;
            4'd1: p_ff[1] <= prod_r;
            4'd2: plane_ff.r00 <= to_entry({prod_r[CW-1], prod_r});
            4'd3: p_ff[2] <= prod_r;
            4'd4: plane_ff.r01 <= to_entry({p_ff[2][CW-1], p_ff[2]} -
                                            {prod_r[CW-1], prod_r});
            4'd5: plane_ff.r10 <= to_entry({prod_r[CW-1], prod_r});
            4'd6: p_ff[3] <= prod_r;
            4'd7: plane_ff.r11 <= to_entry({p_ff[3][CW-1], p_ff[3]} +
                                            {prod_r[CW-1], prod_r});
            4'd8: plane_ff.r21 <= to_entry({prod_r[CW-1], prod_r});
            default: plane_ff.r20 <= to_entry(-{sn_ff[1][CW-1], sn_ff[1]});
         endcase
         plane_ff.tx <= pose_ff.shift_x;
         plane_ff.ty <= pose_ff.shift_y;
         plane_ff.tz <= pose_ff.shift_z;
      end
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);
   assign out_plane = plane_ff;

endmodule

/* rtl/pgpt_queue.sv */
// Two-entry plane queue between setup and emission.
module pgpt_queue
   import pgpt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  plane_type in_plane,
   output logic      out_valid,
   input  logic      out_ready,
   output plane_type out_plane
);

   plane_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_plane = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_plane;
   end

endmodule

/* rtl/pgpt_emit.sv */
// Back: walks the grid, two pipeline stages of multiply-add, output register.
module pgpt_emit
   import pgpt_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 8,
   parameter int unsigned MAX_ROWS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  plane_type   in_plane,
   input  logic [3:0]  grid_columns,
   input  logic [3:0]  grid_rows,
   input  logic [15:0] column_spacing,
   input  logic [15:0] row_spacing,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_x,
   output logic [31:0] out_y,
   output logic [31:0] out_z,
   output logic [2:0]  out_col,
   output logic [2:0]  out_row,
   output logic        out_last
);

   // offsets: (2*i-(n-1)) in -14..14, times 16-bit spacing -> 23 bits signed
   localparam int unsigned HW = 23;
   localparam int unsigned PW = EW + HW + 1;

   logic busy_ff;
   logic [3:0] col_ff, row_ff, ncol_ff, nrow_ff;
   logic [3:0] ncol, nrow;
   plane_type pl_ff;

   logic s1_v_ff, s2_v_ff, o_v_ff;
   logic signed [HW-1:0] xh_ff, yh_ff;
   logic [2:0] s1_c_ff, s1_r_ff, s2_c_ff, s2_r_ff;
   logic s1_l_ff, s2_l_ff;
   logic signed [PW-1:0] ax_ff, bx_ff, ay_ff, by_ff, az_ff, bz_ff;
   logic signed [31:0] tx_ff, ty_ff, tz_ff;

   logic adv, last_pt, take;
   logic signed [6:0] xo, yo;

   always_comb begin
      ncol = grid_columns;
      if (ncol == 4'd0) ncol = 4'd1;
      else if ({1'b0, ncol} > 5'(MAX_COLUMNS)) ncol = 4'(MAX_COLUMNS);
      nrow = grid_rows;
      if (nrow == 4'd0) nrow = 4'd1;
      else if ({1'b0, nrow} > 5'(MAX_ROWS)) nrow = 4'(MAX_ROWS);
   end

   // pipeline moves only when the output register can take a beat;
   // a new plane is taken only on a moving cycle, and the translation
   // travels with the products so points of the previous plane finish intact
   assign adv = !o_v_ff || out_ready;
   assign in_ready = !busy_ff && adv;
   assign take = in_valid && in_ready;
   assign last_pt = (col_ff == ncol_ff - 4'd1) && (row_ff == nrow_ff - 4'd1);
   assign xo = 7'({col_ff, 1'b0}) - 7'(ncol_ff) + 7'sd1;
   assign yo = 7'({row_ff, 1'b0}) - 7'(nrow_ff) + 7'sd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         if (!busy_ff) begin
            if (take) begin
               busy_ff <= 1'b1;
               col_ff <= '0;
               row_ff <= '0;
            end
         end else if (adv) begin
            if (last_pt) busy_ff <= 1'b0;
            else if (col_ff == ncol_ff - 4'd1) begin
               col_ff <= '0;
               row_ff <= row_ff + 4'd1;
            end else col_ff <= col_ff + 4'd1;
         end
         if (adv) begin
            s1_v_ff <= busy_ff;
            s2_v_ff <= s1_v_ff;
            o_v_ff <= s2_v_ff;
         end
      end
   end

   function automatic logic [31:0] fin(input logic signed [PW-1:0] a,
                                       input logic signed [PW-1:0] b,
                                       input logic signed [31:0] t);
      logic signed [PW:0] s;
      logic signed [PW:0] v;
      begin
         s = {a[PW-1], a} + {b[PW-1], b} + (PW+1)'(256);
         v = (s >>> 9) + (PW+1)'(t);
         if (v > (PW+1)'(33'sh0_7FFF_FFFF)) return 32'h7FFF_FFFF;
         else if (v < -(PW+1)'(34'sh0_8000_0000)) return 32'h8000_0000;
         else return v[31:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (take) begin
         pl_ff <= in_plane;
         ncol_ff <= ncol;
         nrow_ff <= nrow;
      end
      if (adv) begin
         xh_ff <= HW'(xo * $signed({1'b0, column_spacing}));
         yh_ff <= HW'(yo * $signed({1'b0, row_spacing}));
         s1_c_ff <= col_ff[2:0];
         s1_r_ff <= row_ff[2:0];
         s1_l_ff <= last_pt;
         ax_ff <= PW'(pl_ff.r00 * xh_ff);
         bx_ff <= PW'(pl_ff.r01 * yh_ff);
         ay_ff <= PW'(pl_ff.r10 * xh_ff);
         by_ff <= PW'(pl_ff.r11 * yh_ff);
         az_ff <= PW'(pl_ff.r20 * xh_ff);
         bz_ff <= PW'(pl_ff.r21 * yh_ff);
         tx_ff <= pl_ff.tx;
         ty_ff <= pl_ff.ty;
         tz_ff <= pl_ff.tz;
         s2_c_ff <= s1_c_ff;
         s2_r_ff <= s1_r_ff;
         s2_l_ff <= s1_l_ff;
         out_x <= fin(ax_ff, bx_ff, tx_ff);
         out_y <= fin(ay_ff, by_ff, ty_ff);
         out_z <= fin(az_ff, bz_ff, tz_ff);
         out_col <= s2_c_ff;
         out_row <= s2_r_ff;
         out_last <= s2_l_ff;
      end
   end

   assign out_valid = o_v_ff;

endmodule

/* rtl/planar_grid_pose_transform.sv */
// channel | dir | beat contents
// req_    | in  | tdata: angle_z, angle_y, angle_x, shift_x, shift_y, shift_z
// rsp_    | out | tdata: point_x, point_y, point_z, column_index, row_index; tlast
// csr_    | in  | csr_index, csr_data
// Setup per pose: taking the beat, the shared CORDIC run for each of the three
// angles, the shared multiplier sequence and a handoff to the plane queue; it
// overlaps emission of the previous pose.
// Emission: one point per cycle unless a point waits on rsp_tready, plus a step
// per pose to take the plane; points pass offset, product and output registers.
// reset is synchronous, active high; clears control state and loads the register defaults.
// rsp_tready low with a point waiting freezes the emit pipeline; the plane queue lets setup run on.
module planar_grid_pose_transform
   import pgpt_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS  = 8,
   parameter int unsigned MAX_ROWS     = 8,
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // angle_z, angle_y, angle_x, shift_x, shift_y, shift_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // point_x, point_y, point_z, column_index, row_index, pad
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic [3:0]  cols_ff, rows_ff;
   logic [15:0] cspc_ff, rspc_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 4'd8;
         rows_ff <= 4'd8;
         cspc_ff <= 16'd256;
         rspc_ff <= 16'd256;
      end else if (csr_valid) begin
         case (csr_index)
            REG_COLUMNS: cols_ff <= csr_data[3:0];
            REG_ROWS:    rows_ff <= csr_data[3:0];
            REG_COL_SPC: cspc_ff <= csr_data[15:0];
            REG_ROW_SPC: rspc_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   pose_type pose;
   assign pose.angle_z = req_tdata[15:0];
   assign pose.angle_y = req_tdata[31:16];
   assign pose.angle_x = req_tdata[47:32];
   assign pose.shift_x = req_tdata[79:48];
   assign pose.shift_y = req_tdata[111:80];
   assign pose.shift_z = req_tdata[143:112];

   logic su_v, su_r, q_v, q_r;
   plane_type su_p, q_p;

   pgpt_setup #(.CORDIC_STEPS(CORDIC_STEPS)) u_setup (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_pose(pose),
      .out_valid(su_v), .out_ready(su_r), .out_plane(su_p)
   );

   pgpt_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(su_v), .in_ready(su_r), .in_plane(su_p),
      .out_valid(q_v), .out_ready(q_r), .out_plane(q_p)
   );

   logic [31:0] px, py, pz;
   logic [2:0] pc, pr;

   pgpt_emit #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_emit (
      .clock(clock), .reset(reset),
      .in_valid(q_v), .in_ready(q_r), .in_plane(q_p),
      .grid_columns(cols_ff), .grid_rows(rows_ff),
      .column_spacing(cspc_ff), .row_spacing(rspc_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_x(px), .out_y(py), .out_z(pz),
      .out_col(pc), .out_row(pr), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {2'b00, pr, pc, pz, py, px};

`ifndef SYNTHESIS
   // a stalled result must hold
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // a finished plane waiting for the queue must hold
   a_queue: assert property (@(posedge clock) disable iff (reset)
      su_v && !su_r |=> su_v && $stable(su_p))
      else $error("plane changed while waiting for the queue");
`endif

endmodule

/* tb/tb.sv */
module tb;
   import pgpt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // One grid point as the block should emit it.
   typedef struct {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [2:0]  col;
      logic [2:0]  row;
      logic        last;
   } grid_point_type;

   localparam int MAX_COLS = 8;
   localparam int MAX_ROWS_P = 8;
   localparam int STEPS = 16;
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam int MAX_WAIT = 17;
   localparam int DRAIN_CYCLES = 120;

   // arctangent of 2^-i in Q30
   localparam longint ARCTAN_Q30 [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;   // angle_z, angle_y, angle_x, shift_x, shift_y, shift_z
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;        // point_x, point_y, point_z, column_index, row_index, pad
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   planar_grid_pose_transform u_top (.*);

   always #5 clock = ~clock;

   // Poses waiting for the driver, points waiting for the block.
   pose_type       pose_q[$];
   grid_point_type point_q[$];
   int             mismatches = 0;
   bit             no_gaps = 1'b0;   // set per phase: back-to-back stretches

   // Predictor's copy of the registers.
   logic [3:0]  cfg_cols = 4'd8;
   logic [3:0]  cfg_rows = 4'd8;
   logic [15:0] cfg_col_spc = 16'd256;
   logic [15:0] cfg_row_spc = 16'd256;

   function automatic longint rnd_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      return rnd_shift(a * b, 30);
   endfunction

   function automatic longint entry_q16(longint q30);
      return clip(rnd_shift(q30, 14), -131072, 131071);
   endfunction

   // Rotation-mode CORDIC; angles past +-pi/2 are folded by pi and the
   // results negated.
   function automatic void cordic_sincos(input logic signed [15:0] ang,
                                         output longint sn, output longint cs);
      longint z, x, y, xn;
      bit     fold;
      z = longint'(ang) * 131072;
      x = GAIN_Q30;
      y = 0;
      fold = 1'b0;
      if (z > HALF_PI_Q30) begin
         z -= PI_Q30;
         fold = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z += PI_Q30;
         fold = 1'b1;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            xn = x - (y >>> i);
            y = y + (x >>> i);
            z -= ARCTAN_Q30[i];
         end else begin
            xn = x + (y >>> i);
            y = y - (x >>> i);
            z += ARCTAN_Q30[i];
         end
         x = xn;
      end
      cs = fold ? -x : x;
      sn = fold ? -y : y;
   endfunction

   // Build R = Rz*Ry*Rx and queue every grid point of the pose.
   task automatic queue_grid_points(input pose_type p);
      longint sz, cz, sy, cy, sx, cx, czsy, szsy;
      longint rot[9];
      longint shift[3];
      longint cols, rows, xh, yh, v;
      grid_point_type gp;
      cordic_sincos(p.angle_z, sz, cz);
      cordic_sincos(p.angle_y, sy, cy);
      cordic_sincos(p.angle_x, sx, cx);
      czsy = mul_q30(cz, sy);
      szsy = mul_q30(sz, sy);
      rot[0] = entry_q16(mul_q30(cz, cy));
      rot[1] = entry_q16(mul_q30(czsy, sx) - mul_q30(sz, cx));
      rot[2] = entry_q16(mul_q30(czsy, cx) + mul_q30(sz, sx));
      rot[3] = entry_q16(mul_q30(sz, cy));
      rot[4] = entry_q16(mul_q30(szsy, sx) + mul_q30(cz, cx));
      rot[5] = entry_q16(mul_q30(szsy, cx) - mul_q30(cz, sx));
      rot[6] = entry_q16(-sy);
      rot[7] = entry_q16(mul_q30(cy, sx));
      rot[8] = entry_q16(mul_q30(cy, cx));
      shift[0] = longint'(p.shift_x);
      shift[1] = longint'(p.shift_y);
      shift[2] = longint'(p.shift_z);
      cols = clip(longint'(cfg_cols), 1, MAX_COLS);
      rows = clip(longint'(cfg_rows), 1, MAX_ROWS_P);
      for (longint r = 0; r < rows; r++) begin
         yh = (2 * r - (rows - 1)) * longint'(cfg_row_spc);
         for (longint c = 0; c < cols; c++) begin
            xh = (2 * c - (cols - 1)) * longint'(cfg_col_spc);
            for (int k = 0; k < 3; k++) begin
               v = rnd_shift(rot[3*k] * xh + rot[3*k+1] * yh, 9);
               v = clip(v + shift[k], -64'sd2147483648, 64'sd2147483647);
               case (k)
                  0: gp.px = v[31:0];
                  1: gp.py = v[31:0];
                  default: gp.pz = v[31:0];
               endcase
            end
            gp.col = c[2:0];
            gp.row = r[2:0];
            gp.last = (r == rows - 1) && (c == cols - 1);
            point_q.push_back(gp);
         end
      end
   endtask

   // Register copy follows the write channel.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            REG_COLUMNS: cfg_cols <= csr_data[3:0];
            REG_ROWS:    cfg_rows <= csr_data[3:0];
            REG_COL_SPC: cfg_col_spc <= csr_data[15:0];
            REG_ROW_SPC: cfg_row_spc <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Pose driver: gap drawn per beat, held until accepted.
   int       send_gap = 0;
   pose_type cur_pose;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (req_tvalid && !req_tready) begin
         // hold the beat
      end else begin
         if (req_tvalid) begin
            queue_grid_points(cur_pose);
            send_gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pose_q.size() > 0) begin
            cur_pose = pose_q.pop_front();
            req_tdata <= {cur_pose.shift_z, cur_pose.shift_y, cur_pose.shift_x,
                          cur_pose.angle_x, cur_pose.angle_y, cur_pose.angle_z};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Point monitor with random stalls; one long hold-off in the middle of
   // the run so the plane queue fills and req_tready drops.
   int  recv_wait = 0;
   int  long_hold = 0;
   int  beats_seen = 0;
   bit  hold_done = 1'b0;
   grid_point_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            if (point_q.size() == 0) begin
               $error("unexpected point beat %h", rsp_tdata);
               mismatches++;
            end else begin
               want = point_q.pop_front();
               if (rsp_tdata[31:0] !== want.px) begin
                  $error("point_x exp %h got %h", want.px, rsp_tdata[31:0]);
                  mismatches++;
               end
               if (rsp_tdata[63:32] !== want.py) begin
                  $error("point_y exp %h got %h", want.py, rsp_tdata[63:32]);
                  mismatches++;
               end
               if (rsp_tdata[95:64] !== want.pz) begin
                  $error("point_z exp %h got %h", want.pz, rsp_tdata[95:64]);
                  mismatches++;
               end
               if (rsp_tdata[98:96] !== want.col) begin
                  $error("column_index exp %0d got %0d", want.col, rsp_tdata[98:96]);
                  mismatches++;
               end
               if (rsp_tdata[101:99] !== want.row) begin
                  $error("row_index exp %0d got %0d", want.row, rsp_tdata[101:99]);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_point exp %0b got %0b", want.last, rsp_tlast);
                  mismatches++;
               end
            end
            recv_wait = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            if (!hold_done && beats_seen >= 1500) begin
               long_hold = 600;
               hold_done = 1'b1;
            end
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [3:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic pose_type make_pose(logic signed [15:0] az, logic signed [15:0] ay,
                                          logic signed [15:0] ax, logic signed [31:0] tx,
                                          logic signed [31:0] ty, logic signed [31:0] tz);
      pose_type p;
      p.angle_z = az;
      p.angle_y = ay;
      p.angle_x = ax;
      p.shift_x = tx;
      p.shift_y = ty;
      p.shift_z = tz;
      return p;
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'(25736);
         1: return -16'(25736);
         2: return 16'($urandom_range(0, 51472) - 25736);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_shift();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
         1: return 32'h8000_0000 + $urandom_range(0, 1 << 20);
         2: return 32'($urandom_range(0, 1 << 22)) - (1 << 21);
         default: return $urandom;
      endcase
   endfunction

   // Wait until the block has handed back every point, then let it settle.
   // Sampled mid-cycle so the driver's queue and valid agree.
   task automatic drain();
      while (pose_q.size() > 0 || req_tvalid || point_q.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 8x8 grid, unit spacing. Angle and shift extremes,
      // quadrant folds, and saturating translations.
      pose_q.push_back(make_pose(0, 0, 0, 0, 0, 0));
      pose_q.push_back(make_pose(16'sd25736, 16'sd25736, 16'sd25736,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      pose_q.push_back(make_pose(-16'sd25736, -16'sd25736, -16'sd25736,
                                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      pose_q.push_back(make_pose(16'sd12868, 16'sd12869, -16'sd12868, 0, 65536, -65536));
      pose_q.push_back(make_pose(16'h7FFF, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF, 1, 0));
      pose_q.push_back(make_pose(16'h8000, 16'h7FFF, 16'h0001, 32'h5555_5555,
                                 32'hAAAA_AAAA, 32'h0F0F_0F0F));
      drain();

      // Out of range grid sizes clamp, zero spacing collapses an axis, and
      // writes past the register list are ignored.
      csr_write(REG_COLUMNS, 32'hFFFF_FFF0);
      csr_write(REG_ROWS, 32'd15);
      csr_write(REG_COL_SPC, 32'd0);
      csr_write(REG_ROW_SPC, 32'hFFFF_FFFF);
      csr_write(4'd7, 32'd3);
      csr_write(4'd15, 32'hFFFF_FFFF);
      pose_q.push_back(make_pose(16'sd6434, -16'sd3217, 16'sd1000, 0, 0, 0));
      pose_q.push_back(make_pose(16'sd25736, 16'sd0, 16'sd25736,
                                 32'h7FFF_0000, 32'h8001_0000, 0));
      drain();
      csr_write(REG_COLUMNS, 32'd15);
      csr_write(REG_ROWS, 32'd0);
      csr_write(REG_COL_SPC, 32'd65535);
      csr_write(REG_ROW_SPC, 32'd0);
      pose_q.push_back(make_pose(16'sd1, -16'sd1, 16'sd20000, 0, 0, 0));
      pose_q.push_back(make_pose(-16'sd20000, 16'sd1, 16'sd25736,
                                 32'h8000_0000, 32'h7FFF_FFFF, 0));
      drain();
      csr_write(REG_COLUMNS, 32'd1);
      csr_write(REG_ROWS, 32'd1);
      csr_write(REG_COL_SPC, 32'd1);
      csr_write(REG_ROW_SPC, 32'd1);
      pose_q.push_back(make_pose(16'sd100, 16'sd200, 16'sd300, 32'd12345, 0, 0));
      drain();

      // Random phases: mostly small grids, a few full-size ones.
      for (int ph = 0; ph < 14; ph++) begin
         no_gaps = (ph % 4 == 1);
         if (ph % 5 == 3) begin
            csr_write(REG_COLUMNS, 32'd8);
            csr_write(REG_ROWS, 32'd8);
         end else begin
            csr_write(REG_COLUMNS, $urandom_range(0, 15) > 12 ? $urandom : $urandom_range(1, 4));
            csr_write(REG_ROWS, $urandom_range(0, 15) > 12 ? $urandom : $urandom_range(1, 4));
         end
         case (ph % 3)
            0: begin
               csr_write(REG_COL_SPC, $urandom);
               csr_write(REG_ROW_SPC, $urandom);
            end
            1: begin
               csr_write(REG_COL_SPC, 32'd65535);
               csr_write(REG_ROW_SPC, 32'd65535);
            end
            default: begin
               csr_write(REG_COL_SPC, $urandom_range(0, 1024));
               csr_write(REG_ROW_SPC, $urandom_range(0, 1024));
            end
         endcase
         for (int n = 0; n < 30; n++)
            pose_q.push_back(make_pose(rand_angle(), rand_angle(), rand_angle(),
                                       rand_shift(), rand_shift(), rand_shift()));
         drain();
      end
      no_gaps = 1'b0;

      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #30ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/pgpt_pkg.sv
rtl/pgpt_setup.sv
rtl/pgpt_queue.sv
rtl/pgpt_emit.sv
rtl/planar_grid_pose_transform.sv
tb/tb.sv
